### src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Request and result structs, command, operator and status codes.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int VAL_W  = 32;
  localparam int NUM_VARS = 6;
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_OP    = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_RS6 = 3'd6,
    OP_RS7 = 3'd7
  } op_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_FEW   = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] var_index;
    logic [2:0] op_code;
  } pse_req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         stack_count;
    logic [2:0]         status;
  } pse_res_t;

  // Operation handed to the arithmetic unit.
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  // Arithmetic unit completion report.
  typedef struct packed {
    logic done;
    logic sat;
    logic dz;
  } alu_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_T,
    S_RD_N,
    S_CALC,
    S_WAIT,
    S_RD_TOP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_POW_MUL,
    A_FIN
  } alu_state_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v,
                                               output logic sat);
    sat = 1'b0;
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return SAT_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

endpackage

### src/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### src/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu: shared Q16.16 arithmetic unit
// Add/sub in one step, one 32x32 multiplier reused for mul and pow,
// restoring divider one quotient bit per cycle for div and mod.
// ----------------------------------------------------------------------------
module pse_alu #(
  parameter int MAX_EXPONENT = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::alu_ctl_t ctl,
  input  logic signed [31:0] n_val,
  input  logic signed [31:0] t_val,
  output pse_pkg::alu_sts_t sts,
  output logic signed [31:0] result
);
  import pse_pkg::*;

  localparam int EXP_W = $clog2(MAX_EXPONENT + 1) + 1;

  alu_state_t st_r, st_nxt;
  op_t        op_r;
  logic signed [31:0] n_r, acc_r, acc_nxt;
  logic       sat_r, sat_nxt, dz_r, dz_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic signed [63:0] prod_r;
  logic       prod_v_r;
  // Divider: unsigned magnitudes, 48-bit dividend.
  logic [47:0] dvd_r, dvd_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;

  logic signed [63:0] add_w, sub_w, shifted;
  logic signed [31:0] sat_v, add_s, sub_s;
  logic sat_f, sat_a, sat_b;
  logic signed [15:0] ti, ni;
  logic [15:0] ti_mag, ni_mag;
  logic [32:0] trial;
  logic [47:0] qmag;
  logic signed [63:0] qsigned;
  logic [31:0] t_mag;
  logic signed [31:0] t_int;

  always_comb begin
    add_w = 64'(n_val) + 64'(t_val);
    sub_w = 64'(n_val) - 64'(t_val);
    add_s = sat64(add_w, sat_a);
    sub_s = sat64(sub_w, sat_b);
    shifted = prod_r >>> 16;
    sat_v = sat64(shifted, sat_f);
    // Integer parts, truncated toward zero.
    t_int = t_val / 32'sd65536;
    ti = t_int[15:0];
    ni = 16'(n_val / 32'sd65536);
    ti_mag = ti[15] ? 16'(-ti) : ti;
    ni_mag = ni[15] ? 16'(-ni) : ni;
    t_mag = t_val[31] ? 32'(-t_val) : 32'(t_val);
    trial = {rem_r[31:0], dvd_r[47]} - {1'b0, dvs_r};
    qmag = dvd_r;
    qsigned = neg_r ? -$signed({16'd0, qmag}) : $signed({16'd0, qmag});
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(n_r) * 64'(acc_r);
    if (st_r == A_IDLE) begin
      n_r <= n_val;
      op_r <= ctl.op;
    end
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
    dz_r  <= dz_nxt;
    exp_r <= exp_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
      prod_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      prod_v_r <= (st_nxt == A_MUL || st_nxt == A_POW_MUL) && !prod_v_r
                  && (st_r == st_nxt);
    end
  end

  always_comb begin
    st_nxt = st_r;
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    dz_nxt = dz_r;
    exp_nxt = exp_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    unique case (st_r)
      A_IDLE: begin
        if (ctl.start) begin
          sat_nxt = 1'b0;
          dz_nxt = 1'b0;
          unique case (ctl.op)
            OP_ADD: begin
              acc_nxt = add_s;
              sat_nxt = sat_a;
              st_nxt = A_FIN;
            end
            OP_SUB: begin
              acc_nxt = sub_s;
              sat_nxt = sat_b;
              st_nxt = A_FIN;
            end
            OP_MUL: begin
              acc_nxt = t_val;
              st_nxt = A_MUL;
            end
            OP_DIV: begin
              if (t_val == 32'sd0) begin
                dz_nxt = 1'b1;
                st_nxt = A_FIN;
              end else begin
                dvd_nxt = {(n_val[31] ? 32'(-n_val) : 32'(n_val)), 16'd0};
                dvs_nxt = t_mag;
                neg_nxt = n_val[31] ^ t_val[31];
                rem_nxt = '0;
                cnt_nxt = 6'd48;
                st_nxt = A_DIV;
              end
            end
            OP_MOD: begin
              if (ti == 16'sd0) begin
                dz_nxt = 1'b1;
                st_nxt = A_FIN;
              end else begin
                dvd_nxt = {ni_mag, 32'd0};
                dvs_nxt = {16'd0, ti_mag};
                neg_nxt = ni[15];
                rem_nxt = '0;
                cnt_nxt = 6'd16;
                st_nxt = A_DIV;
              end
            end
            OP_POW: begin
              acc_nxt = Q_ONE;
              if (t_int <= 32'sd0) begin
                st_nxt = A_FIN;
              end else begin
                exp_nxt = (t_int > 32'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT)
                                                     : EXP_W'(t_int);
                st_nxt = A_POW_MUL;
              end
            end
            default: st_nxt = A_FIN;
          endcase
        end
      end
      A_MUL: begin
        if (prod_v_r) begin
          acc_nxt = sat_v;
          sat_nxt = sat_f;
          st_nxt = A_FIN;
        end
      end
      A_POW_MUL: begin
        if (prod_v_r) begin
          acc_nxt = sat_v;
          sat_nxt = sat_r | sat_f;
          exp_nxt = exp_r - EXP_W'(1);
          if (exp_r == EXP_W'(1)) begin
            st_nxt = A_FIN;
          end
        end
      end
      A_DIV: begin
        if (cnt_r == 6'd0) begin
          if (op_r == OP_DIV) begin
            acc_nxt = sat64(qsigned, sat_nxt);
          end else begin
            acc_nxt = neg_r ? 32'(-$signed({rem_r[15:0], 16'd0}))
                            : $signed({rem_r[15:0], 16'd0});
          end
          st_nxt = A_FIN;
        end else begin
          if (!trial[32]) begin
            rem_nxt = trial;
            dvd_nxt = {dvd_r[46:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[31:0], dvd_r[47]};
            dvd_nxt = {dvd_r[46:0], 1'b0};
          end
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      A_FIN: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  assign sts.done = (st_r == A_FIN);
  assign sts.sat  = sat_r;
  assign sts.dz   = dz_r;
  assign result   = acc_r;

`ifndef SYNTHESIS
  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == A_FIN |=> st_r == A_IDLE) else $error("alu fin stuck");
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == A_FIN && dz_r) |-> (op_r == OP_DIV || op_r == OP_MOD))
    else $error("dz on wrong op");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == A_DIV && cnt_r != 6'd0) |=> cnt_r == $past(cnt_r) - 6'd1)
    else $error("div count");
`endif
endmodule

### src/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: RPN evaluator over a stack of Q16.16 values
// Sequencer around a stack RAM and one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Payload
// in_      | input     | start / busy       | pse_req_t (command, var, op)
// out_     | output    | out_valid strobe   | pse_res_t (top, count, status)
// cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// From the accepting edge a request keeps busy high until its result strobes in
// S_DONE, the last busy state; the next request can be taken in the cycle after.
// Every request passes S_RD_T, S_RD_TOP and S_DONE; a valid operator with enough
// operands also passes S_RD_N, S_CALC and S_WAIT, where the arithmetic unit runs:
// div and mod take one quotient bit per cycle, pow up to MAX_EXPONENT multiplies.
// The stack RAM has one port, so each pop and the top read have their own state.
// Reset clears the count and the sequencer; the stack contents stay unknown
// and only entries below the count are used. Results cannot be stalled.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH  = 64,
  parameter int MAX_EXPONENT = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pse_pkg::pse_req_t in_req,
  output logic              out_valid,
  output pse_pkg::pse_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  pse_req_t req_r;
  logic signed [31:0] var_r [NUM_VARS];
  logic signed [31:0] t_r, n_r;
  logic [2:0] status_r, status_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  alu_ctl_t      actl;
  alu_sts_t      asts;
  logic signed [31:0] ares;

  pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  pse_alu #(.MAX_EXPONENT(MAX_EXPONENT)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .n_val(n_r), .t_val(t_r),
    .sts(asts), .result(ares));

  // Configuration is taken at any time; the contract keeps it to idle periods.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_r[0] <= 32'sd196608;
      var_r[1] <= 32'sd131072;
      var_r[2] <= 32'sd131072;
      var_r[3] <= 32'sd131072;
      var_r[4] <= 32'sd131072;
      var_r[5] <= 32'sd65536;
    end else if (cfg_valid && cfg_index < 3'(NUM_VARS)) begin
      var_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && start) begin
      req_r <= in_req;
    end
    if (st_r == S_RD_N) begin
      t_r <= rdata;
    end
    if (st_r == S_CALC) begin
      n_r <= rdata;
    end
    status_r <= status_nxt;
  end

  assign busy = (st_r != S_IDLE);

  // Sequencer: the RAM address follows the step; read data lands in the next state.
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    status_nxt = status_r;
    we = 1'b0;
    addr = AW'(cnt_r - CW'(1));
    wdata = ares;
    actl.start = 1'b0;
    actl.op = op_t'(req_r.op_code);
    out_valid = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK;
          st_nxt = S_RD_T;
        end
      end
      S_RD_T: begin
        st_nxt = S_RD_TOP;
        unique case (cmd_t'(req_r.command))
          CMD_LOAD: begin
            if (req_r.var_index < 3'(NUM_VARS)) begin
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                we = 1'b1;
                addr = AW'(cnt_r);
                wdata = var_r[req_r.var_index];
                cnt_nxt = cnt_r + CW'(1);
              end
            end
          end
          CMD_OP: begin
            if (req_r.op_code <= 3'(OP_POW)) begin
              if (cnt_r < CW'(2)) begin
                status_nxt = ST_FEW;
              end else begin
                st_nxt = S_RD_N;
              end
            end
          end
          CMD_CLEAR: cnt_nxt = '0;
          default: st_nxt = S_RD_TOP;
        endcase
      end
      S_RD_N: begin
        addr = AW'(cnt_r - CW'(2));
        st_nxt = S_CALC;
      end
      S_CALC: begin
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        actl.start = 1'b1;
        if (asts.done) begin
          actl.start = 1'b0;
          if (asts.dz) begin
            status_nxt = ST_DIVZ;
          end else begin
            we = 1'b1;
            addr = AW'(cnt_r - CW'(2));
            cnt_nxt = cnt_r - CW'(1);
            if (asts.sat) begin
              status_nxt = ST_SAT;
            end
          end
          st_nxt = S_RD_TOP;
        end
      end
      S_RD_TOP: st_nxt = S_DONE;
      S_DONE: begin
        out_valid = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // The top is read in S_RD_TOP and is on the RAM output during S_DONE.
  assign out_res.top_value   = (cnt_r == '0) ? 32'sd0 : $signed(rdata);
  assign out_res.stack_count = 7'(cnt_r);
  assign out_res.status      = status_r;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("count over depth");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && $past(st_r) == S_IDLE) |-> $stable(cnt_r))
    else $error("count moved while idle");
`endif
endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the postfix stack evaluator
// A short table of tokens, most with hand-checked results, opens the run. Then
// random token streams follow, in phases that reload the six variable
// registers and vary the gaps between requests. An in-bench Q16.16 stack
// evaluator predicts the rest, and a monitor compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam int DEPTH   = 64;
  localparam int EXP_CAP = 31;
  localparam int PHASES  = 6;
  localparam int PER_PHASE = 230;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pse_req_t in_req;
  logic     out_valid;
  pse_res_t out_res;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  postfix_stack_evaluator #(.STACK_DEPTH(DEPTH), .MAX_EXPONENT(EXP_CAP)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the evaluator: variable registers, stack and entry count.
  logic signed [31:0] shadow_vars [NUM_VARS];
  logic signed [31:0] shadow_stack [DEPTH];
  int                 shadow_count;

  pse_res_t expected_results [$];
  int errors;
  int tokens_sent;
  int results_seen;
  int sat_seen, divz_seen, full_seen, few_seen;
  int idle_pct;

  // One row of the directed table. Where typed is set, res holds the result
  // worked out by hand; otherwise the shadow evaluator supplies it.
  typedef struct {
    pse_req_t req;
    bit       typed;
    pse_res_t res;
  } token_row_t;

  token_row_t token_table [$];

  function automatic token_row_t row(cmd_t c, logic [2:0] v, logic [2:0] o, bit typed,
                                     logic signed [31:0] top, int cnt, logic [2:0] st);
    token_row_t r;
    r.req.command = c;
    r.req.var_index = v;
    r.req.op_code = o;
    r.typed = typed;
    r.res.top_value = top;
    r.res.stack_count = cnt[6:0];
    r.res.status = st;
    return r;
  endfunction

  // Clamp to the signed 32-bit range and note when clamping happened.
  function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.16 multiply: the arithmetic shift floors toward minus infinity.
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b,
                                              inout bit sat);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16, sat);
  endfunction

  // Advances the shadow state by one token and returns the result it causes.
  function automatic pse_res_t eval_token(pse_req_t req);
    pse_res_t res;
    logic [2:0] st;
    logic signed [31:0] t, n, r;
    longint ni, ti, e;
    bit sat, dz;
    st = ST_OK;
    sat = 1'b0;
    dz = 1'b0;
    r = '0;
    case (cmd_t'(req.command))
      CMD_LOAD: begin
        if (req.var_index < NUM_VARS) begin
          if (shadow_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            shadow_stack[shadow_count] = shadow_vars[req.var_index];
            shadow_count++;
          end
        end
      end
      CMD_OP: begin
        if (req.op_code <= OP_POW) begin
          if (shadow_count < 2) begin
            st = ST_FEW;
          end else begin
            t = shadow_stack[shadow_count-1];
            n = shadow_stack[shadow_count-2];
            case (op_t'(req.op_code))
              OP_ADD: r = clamp32(longint'(n) + longint'(t), sat);
              OP_SUB: r = clamp32(longint'(n) - longint'(t), sat);
              OP_MUL: r = qmul(n, t, sat);
              OP_DIV: begin
                if (t == 0) dz = 1'b1;
                else r = clamp32((longint'(n) * 65536) / longint'(t), sat);
              end
              OP_MOD: begin
                ni = longint'(n) / 65536;
                ti = longint'(t) / 65536;
                if (ti == 0) dz = 1'b1;
                else r = 32'((ni % ti) * 65536);
              end
              default: begin
                e = longint'(t) / 65536;
                if (e > EXP_CAP) e = EXP_CAP;
                r = Q_ONE;
                for (longint k = 0; k < e; k++) r = qmul(r, n, sat);
              end
            endcase
            if (dz) begin
              st = ST_DIVZ;
            end else begin
              shadow_count -= 2;
              shadow_stack[shadow_count] = r;
              shadow_count++;
              if (sat) st = ST_SAT;
            end
          end
        end
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.top_value = shadow_count ? shadow_stack[shadow_count-1] : '0;
    res.stack_count = shadow_count[6:0];
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result monitor. Results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request outstanding", $time);
      end else begin
        pse_res_t want;
        want = expected_results.pop_front();
        results_seen++;
        if (out_res.top_value !== want.top_value)
          report_mismatch("top_value", out_res.top_value, want.top_value);
        if (out_res.stack_count !== want.stack_count)
          report_mismatch("stack_count", out_res.stack_count, want.stack_count);
        if (out_res.status !== want.status)
          report_mismatch("status", out_res.status, want.status);
      end
    end
  end

  // Issues one request and holds it until the block takes it. Start is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_token(pse_req_t req, bit typed, pse_res_t typed_res);
    pse_res_t pred;
    int gap;
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    pred = eval_token(req);
    expected_results.push_back(typed ? typed_res : pred);
    tokens_sent++;
    case (pred.status)
      ST_SAT:  sat_seen++;
      ST_DIVZ: divz_seen++;
      ST_FULL: full_seen++;
      ST_FEW:  few_seen++;
      default: ;
    endcase
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(pse_req_t req);
    send_token(req, 1'b0, '0);
  endtask

  // Waits for every outstanding result, then for the longest operation
  // (a capped power) to be sure the block is idle.
  task automatic drain;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Holds one write until it is taken; the caller lowers cfg_valid after the
  // last write of a burst.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_VARS) shadow_vars[idx] = value;
  endtask

  function automatic logic [31:0] small_q(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic load_setting(int phase);
    logic [31:0] v [NUM_VARS];
    case (phase)
      // Extremes of the Q16.16 range, zero and a fraction.
      1: v = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffff0000, 32'h1, 32'h8000};
      // Small magnitudes, good for powers and long products.
      2: for (int i = 0; i < NUM_VARS; i++) v[i] = small_q(1 << 18);
      // Anything at all.
      3: for (int i = 0; i < NUM_VARS; i++) v[i] = $urandom;
      // Values near one, zero and minus one, and one large value, 40.0.
      4: v = '{32'h0, 32'hffffffff, 32'h00018000, 32'hfffec000, 32'h00010000, 32'h00280000};
      default: for (int i = 0; i < NUM_VARS; i++) v[i] = small_q(1 << 22);
    endcase
    for (int i = 0; i < NUM_VARS; i++) write_reg(3'(i), v[i]);
    // Indexes past the last variable should be ignored.
    if (phase == 4) begin
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // A mostly well-formed token: loads and operators kept in balance, with
  // now and then a clear or an arbitrary bit pattern.
  function automatic pse_req_t random_token();
    pse_req_t req;
    int pick;
    pick = $urandom_range(99);
    req = pse_req_t'(8'($urandom));
    if (pick < 8) return req;
    if (pick < 10) begin
      req.command = CMD_CLEAR;
    end else if (shadow_count < 2 || pick < 52) begin
      req.command = CMD_LOAD;
      req.var_index = 3'($urandom_range(NUM_VARS - 1));
    end else begin
      req.command = CMD_OP;
      req.op_code = 3'($urandom_range(OP_POW));
    end
    return req;
  endfunction

  initial begin
    pse_req_t req;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    tokens_sent = 0;
    results_seen = 0;
    idle_pct = 0;
    shadow_vars = '{32'sd196608, 32'sd131072, 32'sd131072, 32'sd131072, 32'sd131072,
                    32'sd65536};
    shadow_count = 0;

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tokens with the reset values A = 3.0, B..E = 2.0, F = 1.0.
    token_table.push_back(row(CMD_OP, 0, OP_ADD, 1, 0, 0, ST_FEW));
    token_table.push_back(row(CMD_LOAD, 0, 0, 1, 196608, 1, ST_OK));
    token_table.push_back(row(CMD_LOAD, 1, 0, 1, 131072, 2, ST_OK));
    token_table.push_back(row(CMD_OP, 0, OP_SUB, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_OP, 0, OP_MUL, 1, 65536, 1, ST_FEW));
    token_table.push_back(row(CMD_NONE, 7, 7, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_LOAD, 6, 0, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_LOAD, 7, 0, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_OP, 0, OP_RS6, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_OP, 0, OP_RS7, 1, 65536, 1, ST_OK));
    token_table.push_back(row(CMD_CLEAR, 0, 0, 1, 0, 0, ST_OK));
    token_table.push_back(row(CMD_LOAD, 0, 0, 1, 196608, 1, ST_OK));
    token_table.push_back(row(CMD_LOAD, 0, 0, 1, 196608, 2, ST_OK));
    token_table.push_back(row(CMD_LOAD, 0, 0, 1, 196608, 3, ST_OK));
    // 3 - 3 leaves a zero on top, so both division and modulo must refuse.
    token_table.push_back(row(CMD_OP, 0, OP_SUB, 1, 0, 2, ST_OK));
    token_table.push_back(row(CMD_OP, 0, OP_DIV, 1, 0, 2, ST_DIVZ));
    token_table.push_back(row(CMD_OP, 0, OP_MOD, 1, 0, 2, ST_DIVZ));
    token_table.push_back(row(CMD_CLEAR, 0, 0, 1, 0, 0, ST_OK));
    token_table.push_back(row(CMD_LOAD, 2, 0, 0, 0, 0, 0));
    token_table.push_back(row(CMD_LOAD, 5, 0, 0, 0, 0, 0));
    token_table.push_back(row(CMD_OP, 0, OP_DIV, 0, 0, 0, 0));
    token_table.push_back(row(CMD_LOAD, 4, 0, 0, 0, 0, 0));
    token_table.push_back(row(CMD_OP, 0, OP_POW, 0, 0, 0, 0));
    token_table.push_back(row(CMD_LOAD, 3, 0, 0, 0, 0, 0));
    token_table.push_back(row(CMD_OP, 0, OP_MOD, 0, 0, 0, 0));
    token_table.push_back(row(CMD_OP, 0, OP_ADD, 0, 0, 0, 0));
    foreach (token_table[i]) send_token(token_table[i].req, token_table[i].typed,
                                        token_table[i].res);

    // Random phases. Each one reloads the variables while idle, picks a gap
    // pattern, and once fills the stack past its depth.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      load_setting(phase);
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 56;
        default: idle_pct = 12;
      endcase
      for (int i = 0; i < PER_PHASE; i++) begin
        // Halfway through one phase, let the block run completely dry.
        if (phase == 2 && i == PER_PHASE / 2) drain();
        if (i == PER_PHASE / 3) begin
          req = '0;
          req.command = CMD_CLEAR;
          send_plain(req);
          for (int k = 0; k < DEPTH + 2; k++) begin
            req.command = CMD_LOAD;
            req.var_index = 3'($urandom_range(NUM_VARS - 1));
            send_plain(req);
          end
        end
        send_plain(random_token());
      end
    end

    drain();
    $display("Sent %0d tokens over %0d register settings; checked %0d results.",
             tokens_sent, PHASES, results_seen);
    $display("Saturated %0d, divide by zero %0d, stack full %0d, too few operands %0d.",
             sat_seen, divz_seen, full_seen, few_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Generous bound on the whole run of nearly two thousand tokens.
  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
